/* hw/rtl/lbfifo_pkg.sv */
// lbfifo_pkg: shared types and constants for the linear byte fifo
// request and status codes, field widths, controller command struct
// no dependencies
`timescale 1ns / 1ps

package lbfifo_pkg;

  // default store depth in bytes
  localparam int CAPACITY_DEF = 4096;

  // fixed field widths
  localparam int COUNT_W = 13;
  localparam int BYTE_W  = 8;

  // request kind carried in s_tuser
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // per-beat result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // update pointers, touch the store, register the result
  } dp_cmd_t;

endpackage

/* hw/rtl/lbfifo_ctrl.sv */
// lbfifo_ctrl: sequencing state machine for the linear byte fifo
// accept a beat, execute it, then hold the result until taken
// depends on lbfifo_pkg
`timescale 1ns / 1ps

module lbfifo_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output lbfifo_pkg::dp_cmd_t cmd
);
  import lbfifo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake and commands
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign cmd.load = s_tvalid && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

endmodule

/* hw/rtl/lbfifo_datapath.sv */
// lbfifo_datapath: pointers, request bookkeeping and byte store
// decides acceptance on the first beat of a request and moves one byte per beat
// depends on lbfifo_pkg
`timescale 1ns / 1ps

module lbfifo_datapath #(
  parameter int CAPACITY = lbfifo_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lbfifo_pkg::dp_cmd_t                cmd,
  input  logic [1:0]                         req_type,
  input  logic [lbfifo_pkg::COUNT_W-1:0]     count,
  input  logic                               first,
  input  logic [lbfifo_pkg::BYTE_W-1:0]      data_byte,
  output logic [lbfifo_pkg::BYTE_W-1:0]      read_byte,
  output logic [1:0]                         status,
  output logic [lbfifo_pkg::COUNT_W-1:0]     fill_level
);
  import lbfifo_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

  // captured beat
  req_t                item_type;
  logic [COUNT_W-1:0]  item_count;
  logic                item_first;
  logic [BYTE_W-1:0]   item_data;

  // persistent state
  logic [PW-1:0]       rp;
  logic [PW-1:0]       wp;
  status_t             outcome;
  logic [COUNT_W-1:0]  remaining;

  // next values
  logic [PW-1:0]       rp_next;
  logic [PW-1:0]       wp_next;
  status_t             outcome_next;
  logic [COUNT_W-1:0]  remaining_next;
  status_t             status_next;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;

  logic [CW-1:0]       space;
  logic [CW-1:0]       avail;
  logic [CW-1:0]       fill_w;

  // byte store and registered read data
  logic [BYTE_W-1:0]   mem [CAPACITY];
  logic [BYTE_W-1:0]   rd_q;

  // result registers
  logic                rd_flag;
  status_t             status_q;
  logic [COUNT_W-1:0]  fill_q;

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_type  <= req_t'(req_type);
      item_count <= count;
      item_first <= first;
      item_data  <= data_byte;
    end
  end

  // request decision and pointer update
  always_comb begin
    rp_next        = rp;
    wp_next        = wp;
    outcome_next   = outcome;
    remaining_next = remaining;
    status_next    = ST_OK;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    waddr          = wp[AW-1:0];
    raddr          = rp[AW-1:0];
    space          = '0;
    avail          = CW'(wp) - CW'(rp);
    unique case (item_type)
      REQ_WRITE: begin
        if (item_first) begin
          // empty store restarts at the bottom
          if (wp == rp) begin
            rp_next = '0;
            wp_next = '0;
          end
          space = CW'(CAPACITY) - CW'(wp_next);
          if (CW'(item_count) <= space) begin
            outcome_next   = ST_OK;
            remaining_next = item_count;
          end else begin
            outcome_next   = ST_REJECT;
            remaining_next = '0;
          end
        end
        status_next = outcome_next;
        if (outcome_next == ST_OK && remaining_next != '0) begin
          if (wp_next >= PW'(CAPACITY)) begin
            status_next = ST_REJECT;
          end else begin
            mem_we         = 1'b1;
            waddr          = wp_next[AW-1:0];
            wp_next        = wp_next + 1'b1;
            remaining_next = remaining_next - 1'b1;
          end
        end
      end
      REQ_READ: begin
        if (item_first) begin
          remaining_next = '0;
          if (avail == '0) begin
            outcome_next = ST_EMPTY;
          end else if (avail < CW'(item_count)) begin
            outcome_next = ST_REJECT;
          end else begin
            outcome_next   = ST_OK;
            remaining_next = item_count;
          end
        end
        status_next = outcome_next;
        if (outcome_next == ST_OK && remaining_next != '0) begin
          if (rp >= wp || rp >= PW'(CAPACITY)) begin
            status_next = ST_EMPTY;
          end else begin
            mem_re         = 1'b1;
            raddr          = rp[AW-1:0];
            rp_next        = rp + 1'b1;
            remaining_next = remaining_next - 1'b1;
            // drained store restarts at the bottom
            if (rp_next == wp) begin
              rp_next = '0;
              wp_next = '0;
            end
          end
        end
      end
      REQ_FLUSH: begin
        rp_next        = '0;
        wp_next        = '0;
        outcome_next   = ST_OK;
        remaining_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    fill_w = CW'(wp_next) - CW'(rp_next);
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      wp        <= '0;
      outcome   <= ST_OK;
      remaining <= '0;
      rd_flag   <= 1'b0;
    end else if (cmd.exec) begin
      rp        <= rp_next;
      wp        <= wp_next;
      outcome   <= outcome_next;
      remaining <= remaining_next;
      rd_flag   <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_next;
      fill_q   <= fill_w[COUNT_W-1:0];
    end
  end

  // byte store, at most one access per executed beat
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[waddr] <= item_data;
    end
    if (cmd.exec && mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // result
  assign read_byte  = rd_flag ? rd_q : '0;
  assign status     = status_q;
  assign fill_level = fill_q;

endmodule

/* hw/rtl/linear_byte_fifo_reset_on_empty.sv */
// linear_byte_fifo_reset_on_empty: top level of the linear byte fifo
// joins the sequencing controller and the pointer/store datapath
// depends on lbfifo_pkg, lbfifo_ctrl, lbfifo_datapath
`timescale 1ns / 1ps

// Byte fifo with non-wrapping read and write pointers over a store of CAPACITY
// bytes. Requests of count bytes arrive as one beat per byte; the beat marked
// first decides acceptance of the whole request, later beats report the kept
// outcome and move one byte each while bytes remain. Writes into an empty
// store restart both pointers at zero, a read that drains the store does the
// same, and a flush clears everything. Every beat returns exactly one result
// beat. One beat is in flight at a time: a beat is accepted, then executed
// on the single store port with the pointer update, then its result is
// presented and held until m_tready takes it. The store needs no
// clearing pass after reset; only written entries are ever read.
module linear_byte_fifo_reset_on_empty #(
  parameter int CAPACITY = lbfifo_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // count[12:0], first[13], data_byte[21:14], zero[23:22]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_byte[7:0], fill_level[20:8], zero[23:21]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import lbfifo_pkg::*;

  dp_cmd_t              cmd;
  logic [BYTE_W-1:0]    read_byte;
  logic [COUNT_W-1:0]   fill_level;

  // controller
  lbfifo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath
  lbfifo_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (s_tuser),
    .count      (s_tdata[12:0]),
    .first      (s_tdata[13]),
    .data_byte  (s_tdata[21:14]),
    .read_byte  (read_byte),
    .status     (m_tuser),
    .fill_level (fill_level)
  );

  // output packing
  assign m_tdata = {3'b000, fill_level, read_byte};

  // one beat in flight: never accepting while a result is pending
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while result pending");

  // an accepted beat is executed, not followed by another accept
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
    else $error("accepted beat not executed");

  // a taken result frees the input side
  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready)
    else $error("input not ready after result taken");

  // fill level never exceeds the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:8] <= CAPACITY))
    else $error("fill level beyond capacity");

endmodule
